/* rtl/brl_pkg.sv */
package brl_pkg;

    localparam int BRL_COORD_BITS  = 12;
    localparam int BRL_COLOR_BITS  = 4;
    localparam int BRL_QUEUE_DEPTH = 2;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } brl_op_t;

    // step direction of one axis: move = 0 means the axis never changes
    typedef struct packed
    {
        logic neg;
        logic move;
    } brl_dir_t;

endpackage

/* rtl/brl_in_if.sv */
interface brl_in_if
    import brl_pkg::*;
#(
    parameter int COORD_BITS = BRL_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    brl_op_t                      operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [BRL_COLOR_BITS-1:0]    ink;

    modport source
    (
        output valid, operation, start_x, start_y, end_x, end_y, ink,
        input  ready
    );

    modport sink
    (
        input  valid, operation, start_x, start_y, end_x, end_y, ink,
        output ready
    );
endinterface

/* rtl/brl_out_if.sv */
interface brl_out_if
    import brl_pkg::*;
#(
    parameter int COORD_BITS = BRL_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [BRL_COLOR_BITS-1:0]    pixel_color;
    logic                         valid_res;
    logic                         last;

    modport source
    (
        output valid, pixel_x, pixel_y, pixel_color, valid_res, last,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_x, pixel_y, pixel_color, valid_res, last,
        output ready
    );
endinterface

/* rtl/brl_cmd_if.sv */
interface brl_cmd_if
    import brl_pkg::*;
#(
    parameter int COORD_BITS = BRL_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         step;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0]        adx;
    logic [COORD_BITS-1:0]        ady;
    brl_dir_t                     x_dir;
    brl_dir_t                     y_dir;
    logic                         x_major;
    logic [BRL_COLOR_BITS-1:0]    color;

    modport source
    (
        output valid, step, sx, sy, adx, ady, x_dir, y_dir, x_major, color,
        input  ready
    );

    modport sink
    (
        input  valid, step, sx, sy, adx, ady, x_dir, y_dir, x_major, color,
        output ready
    );
endinterface

/* rtl/bresenham_line_rasterizer_top.sv */
// channel | dir | payload                                        | accepted when
// req     | in  | operation start_x start_y end_x end_y ink      | req.valid & req.ready
// rsp     | out | pixel_x pixel_y pixel_color valid_res last     | rsp.valid & rsp.ready
//
// Throughput is one transaction per clock while rsp accepts results; a stall on rsp fills the queue and then holds req.
// A step accepted on req is written into the queue, then into the output register,
// from which it can be taken on rsp.
// Start transactions yield no result. A two-entry queue separates decode from stepping,
// so req can take up to two more transactions while a finished pixel waits on rsp.
// Reset is asynchronous, active low, and leaves no line active.
module bresenham_line_rasterizer_top
    import brl_pkg::*;
#(
    parameter int COORD_BITS  = BRL_COORD_BITS,
    parameter int QUEUE_DEPTH = BRL_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    brl_in_if.sink     req,
    brl_out_if.source  rsp
);

    brl_cmd_if #(.COORD_BITS(COORD_BITS)) decoded ();
    brl_cmd_if #(.COORD_BITS(COORD_BITS)) queued ();

    brl_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .req (req),
        .cmd (decoded)
    );

    brl_queue #(
        .COORD_BITS  (COORD_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (decoded),
        .pop   (queued)
    );

    brl_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (queued),
        .rsp   (rsp)
    );

endmodule

/* rtl/brl_front.sv */
module brl_front
    import brl_pkg::*;
#(
    parameter int COORD_BITS = BRL_COORD_BITS
)
(
    brl_in_if.sink     req,
    brl_cmd_if.source  cmd
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] dx_mag;
    logic signed [COORD_BITS:0] dy_mag;

    // one extra bit so the difference of two coordinates cannot overflow
    assign dx = {req.end_x[COORD_BITS-1], req.end_x} - {req.start_x[COORD_BITS-1], req.start_x};
    assign dy = {req.end_y[COORD_BITS-1], req.end_y} - {req.start_y[COORD_BITS-1], req.start_y};

    assign dx_mag = dx[COORD_BITS] ? -dx : dx;
    assign dy_mag = dy[COORD_BITS] ? -dy : dy;

    assign cmd.valid      = req.valid;
    assign req.ready      = cmd.ready;
    assign cmd.step       = (req.operation == OP_STEP);
    assign cmd.sx         = req.start_x;
    assign cmd.sy         = req.start_y;
    assign cmd.adx        = dx_mag[COORD_BITS-1:0];
    assign cmd.ady        = dy_mag[COORD_BITS-1:0];
    assign cmd.x_dir.neg  = dx[COORD_BITS];
    assign cmd.x_dir.move = |dx;
    assign cmd.y_dir.neg  = dy[COORD_BITS];
    assign cmd.y_dir.move = |dy;
    // tie goes to y as the major axis
    assign cmd.x_major    = (dx_mag[COORD_BITS-1:0] > dy_mag[COORD_BITS-1:0]);
    assign cmd.color      = req.ink;

endmodule

/* rtl/brl_queue.sv */
module brl_queue
    import brl_pkg::*;
#(
    parameter int COORD_BITS  = BRL_COORD_BITS,
    parameter int QUEUE_DEPTH = BRL_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    brl_cmd_if.sink    push,
    brl_cmd_if.source  pop
);

    localparam int ENTRY_BITS = 2 + 4 * COORD_BITS + 2 * $bits(brl_dir_t) + BRL_COLOR_BITS;
    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_BITS-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [ENTRY_BITS-1:0] push_word;
    logic                  do_push;
    logic                  do_pop;

    assign push.ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign do_push    = push.valid && push.ready;
    assign do_pop     = pop.valid && pop.ready;

    assign push_word = {push.step, push.sx, push.sy, push.adx, push.ady,
                        push.x_dir, push.y_dir, push.x_major, push.color};

    assign {pop.step, pop.sx, pop.sy, pop.adx, pop.ady,
            pop.x_dir, pop.y_dir, pop.x_major, pop.color} = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* rtl/brl_back.sv */
module brl_back
    import brl_pkg::*;
#(
    parameter int COORD_BITS = BRL_COORD_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    brl_cmd_if.sink    cmd,
    brl_out_if.source  rsp
);

    // error term and its increments: +-2^(COORD_BITS+1) fits with room to spare
    localparam int DEC_BITS = COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] cur_x_reg,  cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,  cur_y_next;
    logic signed [DEC_BITS-1:0]   dec_reg,    dec_next;
    logic signed [DEC_BITS-1:0]   inc_minor_reg, inc_minor_next;
    logic signed [DEC_BITS-1:0]   inc_both_reg,  inc_both_next;
    brl_dir_t                     x_dir_reg,  x_dir_next;
    brl_dir_t                     y_dir_reg,  y_dir_next;
    logic                         x_major_reg, x_major_next;
    logic [COORD_BITS:0]          left_reg,   left_next;
    logic [BRL_COLOR_BITS-1:0]    color_reg,  color_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] pix_x_reg,  pix_x_next;
    logic signed [COORD_BITS-1:0] pix_y_reg,  pix_y_next;
    logic [BRL_COLOR_BITS-1:0]    pix_color_reg, pix_color_next;
    logic                         valid_res_reg, valid_res_next;
    logic                         last_reg,   last_next;

    logic                         pop;
    logic [COORD_BITS-1:0]        major;
    logic [COORD_BITS-1:0]        minor;
    logic signed [DEC_BITS-1:0]   twice_minor;
    logic signed [DEC_BITS-1:0]   twice_major;
    logic [COORD_BITS-1:0]        x_inc;
    logic [COORD_BITS-1:0]        y_inc;
    logic                         minor_go;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign pop       = cmd.valid && cmd.ready;

    assign major       = cmd.x_major ? cmd.adx : cmd.ady;
    assign minor       = cmd.x_major ? cmd.ady : cmd.adx;
    assign twice_minor = {2'b00, minor, 1'b0};
    assign twice_major = {2'b00, major, 1'b0};

    assign x_inc    = x_dir_reg.move ? (x_dir_reg.neg ? '1 : COORD_BITS'(1)) : '0;
    assign y_inc    = y_dir_reg.move ? (y_dir_reg.neg ? '1 : COORD_BITS'(1)) : '0;
    assign minor_go = !dec_reg[DEC_BITS-1];

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dec_next       = dec_reg;
        inc_minor_next = inc_minor_reg;
        inc_both_next  = inc_both_reg;
        x_dir_next     = x_dir_reg;
        y_dir_next     = y_dir_reg;
        x_major_next   = x_major_reg;
        left_next      = left_reg;
        color_next     = color_reg;

        out_valid_next = out_valid_reg && !rsp.ready;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_color_next = pix_color_reg;
        valid_res_next = valid_res_reg;
        last_next      = last_reg;

        if (pop && !cmd.step)
        begin
            cur_x_next     = cmd.sx;
            cur_y_next     = cmd.sy;
            dec_next       = twice_minor - {3'b000, major};
            inc_minor_next = twice_minor;
            inc_both_next  = twice_minor - twice_major;
            x_dir_next     = cmd.x_dir;
            y_dir_next     = cmd.y_dir;
            x_major_next   = cmd.x_major;
            left_next      = {1'b0, major};
            color_next     = cmd.color;
        end
        else if (pop)
        begin
            out_valid_next = 1'b1;
            if (left_reg == '0)
            begin
                // line finished or never started: empty transaction
                pix_x_next     = '0;
                pix_y_next     = '0;
                pix_color_next = '0;
                valid_res_next = 1'b0;
                last_next      = 1'b0;
            end
            else
            begin
                pix_x_next     = cur_x_reg;
                pix_y_next     = cur_y_reg;
                pix_color_next = color_reg;
                valid_res_next = 1'b1;
                last_next      = (left_reg == (COORD_BITS+1)'(1));

                if (x_major_reg || minor_go)
                begin
                    cur_x_next = cur_x_reg + x_inc;
                end
                if (!x_major_reg || minor_go)
                begin
                    cur_y_next = cur_y_reg + y_inc;
                end
                dec_next  = dec_reg + (minor_go ? inc_both_reg : inc_minor_reg);
                left_next = left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            dec_reg       <= '0;
            inc_minor_reg <= '0;
            inc_both_reg  <= '0;
            x_dir_reg     <= '0;
            y_dir_reg     <= '0;
            x_major_reg   <= 1'b0;
            left_reg      <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            dec_reg       <= dec_next;
            inc_minor_reg <= inc_minor_next;
            inc_both_reg  <= inc_both_next;
            x_dir_reg     <= x_dir_next;
            y_dir_reg     <= y_dir_next;
            x_major_reg   <= x_major_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_color_reg <= pix_color_next;
        valid_res_reg <= valid_res_next;
        last_reg      <= last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pixel_x     = pix_x_reg;
    assign rsp.pixel_y     = pix_y_reg;
    assign rsp.pixel_color = pix_color_reg;
    assign rsp.valid_res   = valid_res_reg;
    assign rsp.last        = last_reg;

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.valid_res |->
            rsp.pixel_x == '0 && rsp.pixel_y == '0 && rsp.pixel_color == '0 && !rsp.last)
        else $error("empty transaction carries nonzero fields");

    a_final_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pop && cmd.step && left_reg == (COORD_BITS+1)'(1) |=>
            left_reg == '0 && rsp.valid && rsp.valid_res && rsp.last)
        else $error("final pixel not flagged or count not exhausted");

    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !cmd.step |=> !rsp.valid)
        else $error("start transaction produced a result");

    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !cmd.step && cmd.adx == '0 && cmd.ady == '0 |=> left_reg == '0)
        else $error("zero-length line left pixels pending");

endmodule
